// ===== sv/scm_pkg.sv =====
// Shared constants, register codes and controller command types for the covariance unit.
package scm_pkg;

    localparam int MAX_VARS    = 8;
    localparam int MAX_SAMPLES = 256;
    localparam int STORE_DEPTH = MAX_VARS * MAX_SAMPLES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int VAR_W       = $clog2(MAX_VARS);
    localparam int VCNT_W      = 4;
    localparam int SCNT_W      = 9;
    localparam int KIDX_W      = $clog2(MAX_SAMPLES);
    localparam int SAMPLE_W    = 32;
    localparam int DEV_W       = SAMPLE_W + 1;
    localparam int MLO_W       = (DEV_W + 1) / 2;
    localparam int MHI_W       = DEV_W - MLO_W;
    localparam int PP_W        = DEV_W + MLO_W;
    localparam int PROD_W      = 2 * DEV_W;
    localparam int ACC_W       = PROD_W + KIDX_W + 2;
    localparam int DIVR_W      = 2 * SCNT_W - 2;
    localparam int QCNT_W      = $clog2(ACC_W + 1);
    localparam int COV_W       = 64;
    localparam int TDATA_W     = 72;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = SCNT_W;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_VAR_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT       = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              acc_clr;
        logic              acc_sample;
        logic              cap_a;
        logic              cap_b;
        logic              mul_lo;
        logic              mul_hi;
        logic              acc_prod;
        logic              div_start;
        logic              div_mean;
        logic              mean_wr;
        logic              mean_a;
        logic              mean_b;
        logic [VAR_W-1:0]  mean_idx;
        logic              out_load;
        logic [VAR_W-1:0]  row;
        logic [VAR_W-1:0]  col;
        logic              last;
        logic [SCNT_W-1:0] ns;
    } scm_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } scm_status_t;

endpackage

// ===== sv/sample_covariance_matrix_unit.sv =====
// Top level of the sample covariance matrix unit: ports, controller and datapath.
// The unit takes V*S Q16.16 samples, by default one variable's S samples after the next
// (REG_LAYOUT = 1 interleaves the variables per sample), one per cycle while s_tready is
// high, then drops s_tready and computes. For each variable it sums S samples and divides
// by S in a 76-step bit-serial divider. It then emits the V*V Q32.32 entries row by row;
// for each entry it fetches the two means, then per sample makes two reads of the single
// read port of the sample RAM, captures the second deviation, forms two partial products
// of a 33x17 multiplier and accumulates, then divides by S*(S-1) and holds the output
// handshake until m_tready is high. The unit takes no new sample until the last entry
// (tlast) has been taken on the m_ side.
module sample_covariance_matrix_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample stream in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [scm_pkg::SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
    // covariance stream out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [scm_pkg::TDATA_W-1:0]    m_tdata,   // [63:0] cov_value, [66:64] row_var,
                                                     // [69:67] col_var, [71:70] zero
    output logic                          m_tuser,   // [0] saturated
    output logic                          m_tlast
);
    import scm_pkg::*;

    scm_cmd_t             cmd;
    scm_status_t          status;
    logic [COV_W-1:0]     cov_value;
    logic [VAR_W-1:0]     row_var, col_var;

    scm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    scm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_sample  (s_tdata),
        .cov_value (cov_value),
        .row_var   (row_var),
        .col_var   (col_var),
        .saturated (m_tuser),
        .last      (m_tlast)
    );

    assign m_tdata = {(TDATA_W - COV_W - 2 * VAR_W)'(0), col_var, row_var, cov_value};

endmodule

// ===== sv/scm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/scm_div.sv =====
// Restoring bit-serial divider: unsigned dividend by a narrow unsigned divisor.
module scm_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [scm_pkg::ACC_W-1:0]  dividend,
    input  logic [scm_pkg::DIVR_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [scm_pkg::ACC_W-1:0]  quotient
);
    import scm_pkg::*;

    logic [ACC_W-1:0]  quo_reg, quo_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dvs_reg, dvs_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVR_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, quo_reg[ACC_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift one dividend bit into the remainder per cycle
            rem_next = fits ? DIVR_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIVR_W-1:0];
            quo_next = {quo_reg[ACC_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == QCNT_W'(ACC_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/scm_dp.sv =====
// Datapath: sample store, deviation capture, split multiplier, accumulator, divider, output word.
module scm_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  scm_pkg::scm_cmd_t           cmd,
    output scm_pkg::scm_status_t        status,
    input  logic [scm_pkg::SAMPLE_W-1:0] s_sample,
    output logic [scm_pkg::COV_W-1:0]    cov_value,
    output logic [scm_pkg::VAR_W-1:0]    row_var,
    output logic [scm_pkg::VAR_W-1:0]    col_var,
    output logic                        saturated,
    output logic                        last
);
    import scm_pkg::*;

    logic [SAMPLE_W-1:0] ram_q;
    logic [SAMPLE_W-1:0] means_reg [MAX_VARS];
    logic [SAMPLE_W-1:0] mean_a_reg, mean_b_reg;
    logic [DEV_W-1:0]    mag_a_reg, mag_b_reg;
    logic                neg_a_reg, neg_b_reg;
    logic [PP_W-1:0]     pp_lo_reg, pp_hi_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [COV_W-1:0]    cov_reg;
    logic [VAR_W-1:0]    row_reg, col_reg;
    logic                sat_reg, last_reg;

    logic [DEV_W-1:0]    dev;
    logic [SAMPLE_W-1:0] dev_mean;
    logic [MLO_W-1:0]    mul_b;
    logic [PP_W-1:0]     mul_p;
    logic [ACC_W-1:0]    prod;
    logic                acc_neg;
    logic [ACC_W-1:0]    acc_mag;
    logic [ACC_W-1:0]    quo;
    logic [DIVR_W-1:0]   d_pairs;
    logic                div_busy, div_done;
    logic [SAMPLE_W-1:0] mean_val;
    logic [COV_W-1:0]    cov_val;
    logic                cov_sat;

    scm_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (s_sample),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (ram_q)
    );

    assign d_pairs = DIVR_W'(cmd.ns) * DIVR_W'(cmd.ns - 1'b1);
    assign acc_neg = acc_reg[ACC_W-1];
    assign acc_mag = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    scm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (acc_mag),
        .divisor  (cmd.div_mean ? DIVR_W'(cmd.ns) : d_pairs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

    assign dev_mean = cmd.cap_a ? mean_a_reg : mean_b_reg;
    assign dev = {ram_q[SAMPLE_W-1], ram_q} - {dev_mean[SAMPLE_W-1], dev_mean};

    assign mul_b = cmd.mul_lo ? mag_b_reg[MLO_W-1:0]
                              : MLO_W'(mag_b_reg[DEV_W-1:MLO_W]);
    assign mul_p = PP_W'(mag_a_reg) * PP_W'(mul_b);
    assign prod  = ACC_W'(pp_lo_reg) + (ACC_W'(pp_hi_reg) << MLO_W);

    assign mean_val = acc_neg ? SAMPLE_W'(-quo[SAMPLE_W-1:0]) : quo[SAMPLE_W-1:0];

    always_comb begin
        cov_sat = 1'b0;
        cov_val = quo[COV_W-1:0];
        if (!acc_neg) begin
            if (quo[ACC_W-1:COV_W-1] != '0) begin
                cov_sat = 1'b1;
                cov_val = {1'b0, {(COV_W-1){1'b1}}};
            end
        end else begin
            if (quo[ACC_W-1:COV_W] != '0 || (quo[COV_W-1] && quo[COV_W-2:0] != '0)) begin
                cov_sat = 1'b1;
                cov_val = {1'b1, {(COV_W-1){1'b0}}};
            end else begin
                cov_val = COV_W'(-quo[COV_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mean_wr) begin
            means_reg[cmd.mean_idx] <= mean_val;
        end
        if (cmd.mean_a) begin
            mean_a_reg <= means_reg[cmd.mean_idx];
        end
        if (cmd.mean_b) begin
            mean_b_reg <= means_reg[cmd.mean_idx];
        end
        if (cmd.cap_a) begin
            neg_a_reg <= dev[DEV_W-1];
            mag_a_reg <= dev[DEV_W-1] ? DEV_W'(-dev) : dev;
        end
        if (cmd.cap_b) begin
            neg_b_reg <= dev[DEV_W-1];
            mag_b_reg <= dev[DEV_W-1] ? DEV_W'(-dev) : dev;
        end
        if (cmd.mul_lo) begin
            pp_lo_reg <= mul_p;
        end
        if (cmd.mul_hi) begin
            pp_hi_reg <= mul_p;
        end
        priority if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_sample) begin
            acc_reg <= acc_reg + ACC_W'(signed'(ram_q));
        end else if (cmd.acc_prod) begin
            acc_reg <= (neg_a_reg ^ neg_b_reg) ? acc_reg - signed'(prod)
                                               : acc_reg + signed'(prod);
        end
        if (cmd.out_load) begin
            cov_reg  <= cov_val;
            sat_reg  <= cov_sat;
            row_reg  <= cmd.row;
            col_reg  <= cmd.col;
            last_reg <= cmd.last;
        end
    end

    assign cov_value = cov_reg;
    assign row_var   = row_reg;
    assign col_var   = col_reg;
    assign saturated = sat_reg;
    assign last      = last_reg;

endmodule

// ===== sv/scm_ctrl.sv =====
// Controller: configuration registers, load counter and the sequencer over variables and samples.
module scm_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output scm_pkg::scm_cmd_t             cmd,
    input  scm_pkg::scm_status_t          status
);
    import scm_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_MRD, S_MACC, S_MDS, S_MDW, S_MST,
        S_PMA, S_PMB, S_RA, S_RB, S_CB, S_ML, S_MH, S_ACC,
        S_DS, S_DW, S_OUT, S_OWAIT
    } state_t;

    state_t             state_reg, state_next;
    logic [VCNT_W-1:0]  var_count_reg, var_count_next;
    logic [SCNT_W-1:0]  sample_count_reg, sample_count_next;
    logic               layout_reg, layout_next;
    logic [ADDR_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [VAR_W-1:0]   i_reg, i_next;
    logic [VAR_W-1:0]   j_reg, j_next;
    logic [KIDX_W-1:0]  k_reg, k_next;

    logic [VCNT_W-1:0]  nv;
    logic [SCNT_W-1:0]  ns;
    logic [CNT_W-1:0]   total;
    logic [VAR_W-1:0]   last_v;
    logic [KIDX_W-1:0]  last_k;
    logic [VAR_W-1:0]   sel_var;
    logic [CNT_W-1:0]   addr_full;
    logic               accept, cfg_hit, last_pair;

    assign nv = (var_count_reg == '0) ? VCNT_W'(1)
              : (var_count_reg > VCNT_W'(MAX_VARS)) ? VCNT_W'(MAX_VARS) : var_count_reg;
    assign ns = (sample_count_reg < SCNT_W'(2)) ? SCNT_W'(2)
              : (sample_count_reg > SCNT_W'(MAX_SAMPLES)) ? SCNT_W'(MAX_SAMPLES)
              : sample_count_reg;
    assign total  = CNT_W'(nv) * CNT_W'(ns);
    assign last_v = VAR_W'(nv - 1'b1);
    assign last_k = KIDX_W'(ns - 1'b1);

    assign sel_var   = (state_reg == S_RB) ? j_reg : i_reg;
    assign addr_full = layout_reg ? CNT_W'(k_reg) * CNT_W'(nv) + CNT_W'(sel_var)
                                  : CNT_W'(sel_var) * CNT_W'(ns) + CNT_W'(k_reg);

    assign s_tready  = (state_reg == S_LOAD);
    assign m_tvalid  = (state_reg == S_OWAIT);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign cfg_hit   = cfg_valid && cfg_ready;
    assign last_pair = (i_reg == last_v) && (j_reg == last_v);

    always_comb begin
        cmd            = '0;
        cmd.wr_addr    = load_cnt_reg;
        cmd.rd_addr    = addr_full[ADDR_W-1:0];
        cmd.row        = i_reg;
        cmd.col        = j_reg;
        cmd.last       = last_pair;
        cmd.ns         = ns;
        cmd.mean_idx   = i_reg;

        state_next        = state_reg;
        var_count_next    = var_count_reg;
        sample_count_next = sample_count_reg;
        layout_next       = layout_reg;
        load_cnt_next     = load_cnt_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;

        unique case (state_reg)
            S_LOAD: begin
                cmd.wr_en   = accept;
                cmd.acc_clr = 1'b1;
                if (accept) begin
                    if (CNT_W'(load_cnt_reg) + 1'b1 == total) begin
                        load_cnt_next = '0;
                        i_next        = '0;
                        k_next        = '0;
                        state_next    = S_MRD;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            S_MRD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_MACC;
            end
            S_MACC: begin
                cmd.acc_sample = 1'b1;
                if (k_reg == last_k) begin
                    k_next     = '0;
                    state_next = S_MDS;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_MRD;
                end
            end
            S_MDS: begin
                cmd.div_start = 1'b1;
                cmd.div_mean  = 1'b1;
                state_next    = S_MDW;
            end
            S_MDW: begin
                if (status.div_done) begin
                    state_next = S_MST;
                end
            end
            S_MST: begin
                cmd.mean_wr = 1'b1;
                cmd.acc_clr = 1'b1;
                if (i_reg == last_v) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_PMA;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_MRD;
                end
            end
            S_PMA: begin
                cmd.mean_a  = 1'b1;
                cmd.acc_clr = 1'b1;
                k_next      = '0;
                state_next  = S_PMB;
            end
            S_PMB: begin
                cmd.mean_b   = 1'b1;
                cmd.mean_idx = j_reg;
                state_next   = S_RA;
            end
            S_RA: begin
                cmd.rd_en  = 1'b1;
                state_next = S_RB;
            end
            S_RB: begin
                cmd.rd_en  = 1'b1;
                cmd.cap_a  = 1'b1;
                state_next = S_CB;
            end
            S_CB: begin
                cmd.cap_b  = 1'b1;
                state_next = S_ML;
            end
            S_ML: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MH;
            end
            S_MH: begin
                cmd.mul_hi = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc_prod = 1'b1;
                if (k_reg == last_k) begin
                    state_next = S_DS;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RA;
                end
            end
            S_DS: begin
                cmd.div_start = 1'b1;
                state_next    = S_DW;
            end
            S_DW: begin
                if (status.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                cmd.out_load = 1'b1;
                state_next   = S_OWAIT;
            end
            S_OWAIT: begin
                // hold the word until taken, then step to the next pair, or back to loading after the last pair
                if (m_tready) begin
                    if (last_pair) begin
                        state_next = S_LOAD;
                    end else if (j_reg == last_v) begin
                        j_next     = '0;
                        i_next     = i_reg + 1'b1;
                        state_next = S_PMA;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_PMA;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase

        if (cfg_hit) begin
            unique case (cfg_index)
                REG_VAR_COUNT: begin
                    var_count_next = cfg_data[VCNT_W-1:0];
                    load_cnt_next  = '0;
                end
                REG_SAMPLE_COUNT: begin
                    sample_count_next = cfg_data;
                    load_cnt_next     = '0;
                end
                REG_LAYOUT: begin
                    layout_next   = cfg_data[0];
                    load_cnt_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_LOAD;
            var_count_reg    <= VCNT_W'(MAX_VARS);
            sample_count_reg <= SCNT_W'(MAX_SAMPLES);
            layout_reg       <= 1'b0;
            load_cnt_reg     <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
        end else begin
            state_reg        <= state_next;
            var_count_reg    <= var_count_next;
            sample_count_reg <= sample_count_next;
            layout_reg       <= layout_next;
            load_cnt_reg     <= load_cnt_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
        end
    end

    a_load_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (CNT_W'(load_cnt_reg) < total))
        else $error("load counter beyond matrix size");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_word_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(status.div_done, 2))
        else $error("result word raised without a finished division");

endmodule
